// ===== hw/rtl/abpd_pkg.sv =====
// ----------------------------------------------------------------------------
// abpd_pkg
// Shared types and constants of the angle-bracket packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package abpd_pkg;

  localparam logic [7:0] START_CH = 8'h3E;  // '>'
  localparam logic [7:0] END_CH   = 8'h3C;  // '<'
  localparam logic [7:0] NL_CH    = 8'h0A;  // newline

  localparam int MAX_PAYLOAD_DEF = 256;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] ftype;
    logic [7:0] check;
    logic [8:0] len;
  } result_t;

  // Results produced by one accepted byte: none, one, or two in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/abpd_core.sv =====
// ----------------------------------------------------------------------------
// abpd_core
// Frame hunting state, body delay line and result generation for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module abpd_core #(
  parameter int MAX_PAYLOAD = abpd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire logic [7:0]     rx_byte,
  output abpd_pkg::push_t     push
);
  import abpd_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 4);
  localparam int EXT_W = (CNT_W > 9) ? CNT_W : 9;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PAYLOAD + 3);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_FOUR  = CNT_W'(4);

  typedef enum logic [3:0] {
    S_HUNT = 4'b0001,
    S_ONE  = 4'b0010,
    S_TYPE = 4'b0100,
    S_BODY = 4'b1000
  } mode_t;

  mode_t            mode, mode_next;
  logic [CNT_W-1:0] body_count, body_count_next;
  logic [7:0]       frame_type_reg, frame_type_reg_next;
  logic [7:0]       recent [4];
  logic             shift_en;
  logic             closing;
  logic [EXT_W-1:0] len_ext;
  result_t          res_payload, res_done, res_over;

  assign closing = (rx_byte == NL_CH) && (body_count >= CNT_THREE) &&
                   (recent[3] == END_CH) && (recent[2] == END_CH);
  assign len_ext = EXT_W'(body_count) - EXT_W'(3);

  always_comb begin
    res_payload       = '0;
    res_payload.kind  = KIND_PAYLOAD;
    res_payload.data  = recent[0];
    res_payload.ftype = frame_type_reg;

    res_done       = '0;
    res_done.kind  = KIND_DONE;
    res_done.ftype = frame_type_reg;
    res_done.check = recent[1];
    res_done.len   = len_ext[8:0];

    res_over       = '0;
    res_over.kind  = KIND_OVERFLOW;
    res_over.ftype = frame_type_reg;
  end

  always_comb begin
    mode_next           = mode;
    body_count_next     = body_count;
    frame_type_reg_next = frame_type_reg;
    shift_en            = 1'b0;
    push                = '0;
    push.first          = res_payload;
    push.second         = res_done;
    if (fire) begin
      unique case (mode)
        S_HUNT: begin
          if (rx_byte == START_CH) mode_next = S_ONE;
        end
        S_ONE: begin
          mode_next = (rx_byte == START_CH) ? S_TYPE : S_HUNT;
        end
        S_TYPE: begin
          frame_type_reg_next = rx_byte;
          body_count_next     = '0;
          mode_next           = S_BODY;
        end
        S_BODY: begin
          priority if (closing) begin
            // A held payload byte goes out ahead of the frame-complete result.
            if (body_count >= CNT_FOUR) begin
              push.count = 2'd2;
            end else begin
              push.count = 2'd1;
              push.first = res_done;
            end
            mode_next       = S_HUNT;
            body_count_next = '0;
          end else if (body_count == CNT_LIMIT) begin
            push.count      = 2'd1;
            push.first      = res_over;
            mode_next       = S_HUNT;
            body_count_next = '0;
          end else begin
            if (body_count >= CNT_FOUR) push.count = 2'd1;
            shift_en        = 1'b1;
            body_count_next = body_count + 1'b1;
          end
        end
        default: begin
          mode_next = S_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= S_HUNT;
      body_count <= '0;
    end else begin
      mode       <= mode_next;
      body_count <= body_count_next;
    end
  end

  // The delay line is always refilled before a frame reads it.
  always_ff @(posedge clk) begin
    frame_type_reg <= frame_type_reg_next;
    if (shift_en) begin
      recent[0] <= recent[1];
      recent[1] <= recent[2];
      recent[2] <= recent[3];
      recent[3] <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/abpd_outq.sv =====
// ----------------------------------------------------------------------------
// abpd_outq
// Small result queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module abpd_outq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire abpd_pkg::push_t push,
  input  wire logic          pop,
  output logic               not_empty,
  output logic               nearly_full,
  output abpd_pkg::result_t  head
);
  import abpd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W-1:0] wr_ptr_plus;
  logic [CNT_W-1:0] fill;

  assign wr_ptr_plus = wr_ptr + 1'b1;
  assign not_empty   = (fill != '0);
  // Room must exist for the two results a closing byte can produce.
  assign nearly_full = (fill > CNT_W'(QUEUE_DEPTH - 2));
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      fill   <= fill + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr_plus] <= push.second;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/angle_bracket_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// angle_bracket_packet_deframer
// Finds '>' '>' type body check '<' '<' newline frames in a byte stream.
// ----------------------------------------------------------------------------
// The block accepts one received byte per clock and turns it into zero, one
// or two results through a four-entry result queue: payload bytes (given out
// four body bytes late), a frame-complete result carrying type, check byte and
// payload length, or an overflow result when a body exceeds MAX_PAYLOAD bytes.
// A result can be taken the cycle after its byte is transferred. The input
// side stalls only while fewer than two queue entries are free, which occurs
// only when the output side has been stalling; otherwise throughput is one
// byte per cycle. No clearing pass follows reset.
`default_nettype none

module angle_bracket_packet_deframer #(
  parameter int MAX_PAYLOAD = abpd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [7:0]       frame_type,
  output logic [7:0]       check_byte,
  output logic [8:0]       payload_length
);
  import abpd_pkg::*;

  push_t   push;
  result_t head;
  logic    q_not_empty, q_nearly_full;
  logic    in_fire, out_fire;

  assign in_stall = q_nearly_full;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  abpd_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (in_fire),
    .rx_byte(rx_byte),
    .push   (push)
  );

  abpd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (out_fire),
    .not_empty  (q_not_empty),
    .nearly_full(q_nearly_full),
    .head       (head)
  );

  assign out_valid      = q_not_empty;
  assign kind           = head.kind;
  assign data_byte      = head.data;
  assign frame_type     = head.ftype;
  assign check_byte     = head.check;
  assign payload_length = head.len;

endmodule

`default_nettype wire

// ===== hw/rtl/abpd_checker.sv =====
// ----------------------------------------------------------------------------
// abpd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abpd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] rx_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] kind,
  input wire logic [7:0] data_byte,
  input wire logic [7:0] frame_type,
  input wire logic [7:0] check_byte,
  input wire logic [8:0] payload_length
);
  import abpd_pkg::*;

  // A stalled result stays offered with the same contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte) &&
      $stable(frame_type) && $stable(check_byte) && $stable(payload_length))
    else $error("stalled result changed");

  // The queue is empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_PAYLOAD || kind == KIND_DONE || kind == KIND_OVERFLOW))
    else $error("undefined result kind");

  // Fields that do not belong to a kind read as zero.
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PAYLOAD |-> check_byte == 8'd0 && payload_length == 9'd0)
    else $error("payload result carries frame fields");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PAYLOAD |-> data_byte == 8'd0)
    else $error("non-payload result carries a data byte");

endmodule

bind angle_bracket_packet_deframer abpd_checker u_abpd_checker (.*);

`default_nettype wire
